// ===== rtl/glrs_pkg.sv =====
// Shared types and constants for the gated linear recurrence scan.
`timescale 1ns / 1ps
package glrs_pkg;

  localparam int CHANNELS = 64;
  localparam int CH_W     = 6;
  localparam int CFG_W    = 7;
  localparam int GATE_W   = 17;
  localparam int VAL_W    = 32;
  localparam int PROD_W   = VAL_W + GATE_W + 1;
  localparam int FRAC_W   = 16;

  localparam logic [CFG_W-1:0]  CHANNELS_RESET = CFG_W'(CHANNELS);
  localparam logic [GATE_W-1:0] GATE_ONE       = GATE_W'(1 << FRAC_W);

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic                    opcode;
    logic [CH_W-1:0]         channel;
    logic [GATE_W-1:0]       gate;
    logic signed [VAL_W-1:0] x_value;
    logic                    final_step;
    logic                    bad;
  } stage_t;

endpackage

// ===== rtl/glrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module glrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gated_linear_recurrence_scan.sv =====
// Top level of the per-channel gated first-order recurrence scan.
//
//   channel   handshake                 payload
//   item      item_valid / item_ready   opcode, channel, gate, x_value, final_step
//   result    result_valid / result_ready s_value, saturated, bad_channel, final_out
//   config    config_write              config_data (channels_in_use)
//
// One item per cycle unless stalled; items pass s1, then the result register.
// The state memory read is registered; a write in the same cycle is forwarded.
// Reset clears channels_in_use to 64; per-entry valid bits make state read zero.
// A held result register stalls the compute stage and drops item_ready.
`timescale 1ns / 1ps
module gated_linear_recurrence_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                config_write,
  input  logic [glrs_pkg::CFG_W-1:0]          config_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                opcode,
  input  logic [glrs_pkg::CH_W-1:0]           channel,
  input  logic [glrs_pkg::GATE_W-1:0]         gate,
  input  logic signed [glrs_pkg::VAL_W-1:0]   x_value,
  input  logic                                final_step,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [glrs_pkg::VAL_W-1:0]   s_value,
  output logic                                saturated,
  output logic                                bad_channel,
  output logic                                final_out
);

  logic [glrs_pkg::CFG_W-1:0]        channels_in_use;
  glrs_pkg::stage_t                  s1;
  glrs_pkg::stage_t                  s1_next;
  logic                              s1_valid;
  logic                              s1_fire;
  logic                              item_fire;
  logic [glrs_pkg::CHANNELS-1:0]     vbits;
  logic                              vld_rd;
  logic                              byp;
  logic [glrs_pkg::VAL_W-1:0]        byp_data;
  logic [glrs_pkg::VAL_W-1:0]        ram_q;
  logic [glrs_pkg::CH_W-1:0]         rd_addr;
  logic                              wr_en;
  logic signed [glrs_pkg::VAL_W-1:0] state_old;
  logic [glrs_pkg::GATE_W-1:0]       gate_c;
  logic signed [glrs_pkg::PROD_W-1:0] prod;
  logic signed [glrs_pkg::PROD_W-1:0] prod_rnd;
  logic signed [glrs_pkg::VAL_W:0]   rnd;
  logic signed [glrs_pkg::VAL_W+1:0] sum;
  logic                              sum_sat;
  logic signed [glrs_pkg::VAL_W-1:0] sum_clip;
  logic signed [glrs_pkg::VAL_W-1:0] res_value;
  logic                              res_sat;

  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;
  assign item_fire  = item_valid && item_ready;
  assign rd_addr    = item_fire ? channel : s1.channel;
  assign wr_en      = s1_fire && !s1.bad;

  always_comb begin
    s1_next.opcode     = opcode;
    s1_next.channel    = channel;
    s1_next.gate       = gate;
    s1_next.x_value    = x_value;
    s1_next.final_step = final_step;
    s1_next.bad        = ({1'b0, channel} >= channels_in_use)
                      || ({1'b0, channel} >= glrs_pkg::CFG_W'(glrs_pkg::CHANNELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= glrs_pkg::CHANNELS_RESET;
    end else if (config_write) begin
      channels_in_use <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1 <= s1_next;
    end
  end

  glrs_ram #(
    .WIDTH (glrs_pkg::VAL_W),
    .DEPTH (glrs_pkg::CHANNELS)
  ) u_state (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.channel),
    .wdata (res_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      vld_rd <= 1'b0;
      byp    <= 1'b0;
    end else begin
      vld_rd <= vbits[rd_addr];
      byp    <= wr_en && (s1.channel == rd_addr);
      if (wr_en) begin
        vbits[s1.channel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= res_value;
  end

  always_comb begin
    state_old = byp ? byp_data : (vld_rd ? ram_q : '0);
    gate_c    = (s1.gate > glrs_pkg::GATE_ONE) ? glrs_pkg::GATE_ONE : s1.gate;
    prod      = state_old * $signed({1'b0, gate_c});
    prod_rnd  = prod + glrs_pkg::PROD_W'(1 << (glrs_pkg::FRAC_W - 1));
    rnd       = prod_rnd[glrs_pkg::VAL_W + glrs_pkg::FRAC_W:glrs_pkg::FRAC_W];
    sum       = {rnd[glrs_pkg::VAL_W], rnd}
              + {{2{s1.x_value[glrs_pkg::VAL_W-1]}}, s1.x_value};
    sum_sat   = (sum[glrs_pkg::VAL_W+1:glrs_pkg::VAL_W-1] != 3'b000)
             && (sum[glrs_pkg::VAL_W+1:glrs_pkg::VAL_W-1] != 3'b111);
    if (!sum_sat) begin
      sum_clip = sum[glrs_pkg::VAL_W-1:0];
    end else if (sum[glrs_pkg::VAL_W+1]) begin
      sum_clip = glrs_pkg::VAL_MIN;
    end else begin
      sum_clip = glrs_pkg::VAL_MAX;
    end
    if (s1.bad) begin
      res_value = '0;
      res_sat   = 1'b0;
    end else if (s1.opcode == glrs_pkg::OP_LOAD) begin
      res_value = s1.x_value;
      res_sat   = 1'b0;
    end else begin
      res_value = sum_clip;
      res_sat   = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s_value     <= res_value;
      saturated   <= res_sat;
      bad_channel <= s1.bad;
      final_out   <= s1.final_step;
    end
  end

  a_bad_result_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_channel |-> (s_value == '0) && !saturated)
    else $error("bad channel result carries a value");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      (s_value == glrs_pkg::VAL_MAX) || (s_value == glrs_pkg::VAL_MIN))
    else $error("saturated result is not at a range limit");

  a_load_passes: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1.bad && (s1.opcode == glrs_pkg::OP_LOAD)
      |=> s_value == $past(s1.x_value))
    else $error("load result differs from loaded value");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> item_ready)
    else $error("item stalled with empty compute stage");

  a_bad_no_write: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.bad |-> !wr_en)
    else $error("bad channel item writes state");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the gated linear recurrence scan: table-driven and random items.
`timescale 1ns / 1ps
module testbench;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [glrs_pkg::VAL_W-1:0] s_value;
    logic                              saturated;
    logic                              bad_channel;
    logic                              final_out;
  } scan_result_t;

  typedef struct {
    row_kind_t                         kind;
    logic                              op;
    logic [glrs_pkg::CH_W-1:0]         ch;
    logic [glrs_pkg::GATE_W-1:0]       g;
    logic signed [glrs_pkg::VAL_W-1:0] x;
    logic                              fin;
    bit                                typed;
    logic signed [glrs_pkg::VAL_W-1:0] s;
    logic                              sat;
    logic                              bad;
  } scan_row_t;

  logic                              clk;
  logic                              rst;
  logic                              config_write;
  logic [glrs_pkg::CFG_W-1:0]        config_data;
  logic                              item_valid;
  logic                              item_ready;
  logic                              opcode;
  logic [glrs_pkg::CH_W-1:0]         channel;
  logic [glrs_pkg::GATE_W-1:0]       gate;
  logic signed [glrs_pkg::VAL_W-1:0] x_value;
  logic                              final_step;
  logic                              result_valid;
  logic                              result_ready;
  logic signed [glrs_pkg::VAL_W-1:0] s_value;
  logic                              saturated;
  logic                              bad_channel;
  logic                              final_out;

  logic signed [glrs_pkg::VAL_W-1:0] chan_state [glrs_pkg::CHANNELS];
  logic [glrs_pkg::CFG_W-1:0]        chan_limit;
  scan_result_t                      state_results [$];
  scan_row_t                         dir_rows [$];
  bit                                note_typed;
  scan_result_t                      note_exp;
  int                                fail_count;
  int                                tx_calm;
  int                                rx_calm;

  gated_linear_recurrence_scan u_dut (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_data  (config_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .channel      (channel),
    .gate         (gate),
    .x_value      (x_value),
    .final_step   (final_step),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .s_value      (s_value),
    .saturated    (saturated),
    .bad_channel  (bad_channel),
    .final_out    (final_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic scan_result_t advance_channel(logic op, logic [glrs_pkg::CH_W-1:0] ch,
                                                   logic [glrs_pkg::GATE_W-1:0] g,
                                                   logic signed [glrs_pkg::VAL_W-1:0] x,
                                                   logic fin);
    scan_result_t r;
    logic [glrs_pkg::GATE_W-1:0] gc;
    longint sl;
    longint gl;
    longint sum;
    r = '0;
    r.final_out = fin;
    if (ch >= chan_limit || ch >= glrs_pkg::CHANNELS) begin
      r.bad_channel = 1'b1;
    end else if (op == glrs_pkg::OP_LOAD) begin
      chan_state[ch] = x;
      r.s_value = x;
    end else begin
      gc = (g > glrs_pkg::GATE_ONE) ? glrs_pkg::GATE_ONE : g;
      sl = chan_state[ch];
      gl = gc;
      sum = ((sl * gl + 64'sd32768) >>> glrs_pkg::FRAC_W) + longint'(x);
      if (sum > longint'(glrs_pkg::VAL_MAX)) begin
        sum = glrs_pkg::VAL_MAX;
        r.saturated = 1'b1;
      end else if (sum < longint'(glrs_pkg::VAL_MIN)) begin
        sum = glrs_pkg::VAL_MIN;
        r.saturated = 1'b1;
      end
      chan_state[ch] = sum[glrs_pkg::VAL_W-1:0];
      r.s_value = sum[glrs_pkg::VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic scan_row_t make_row(row_kind_t kind, logic op,
                                         logic [glrs_pkg::CH_W-1:0] ch,
                                         logic [glrs_pkg::GATE_W-1:0] g,
                                         logic signed [glrs_pkg::VAL_W-1:0] x,
                                         logic fin, bit typed,
                                         logic signed [glrs_pkg::VAL_W-1:0] s,
                                         logic sat, logic bad);
    scan_row_t r;
    r.kind = kind;
    r.op = op;
    r.ch = ch;
    r.g = g;
    r.x = x;
    r.fin = fin;
    r.typed = typed;
    r.s = s;
    r.sat = sat;
    r.bad = bad;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    scan_result_t want;
    if (rst) begin
      chan_limit = glrs_pkg::CHANNELS_RESET;
      foreach (chan_state[i]) chan_state[i] = '0;
    end else begin
      if (item_valid && item_ready) begin
        want = advance_channel(opcode, channel, gate, x_value, final_step);
        if (note_typed) begin
          want = note_exp;
        end
        state_results.push_back(want);
      end
      if (result_valid && result_ready) begin
        if (state_results.size() == 0) begin
          $error("result transfer with no expected result: s_value %0d", s_value);
          fail_count++;
        end else begin
          want = state_results.pop_front();
          if (s_value !== want.s_value) begin
            $error("s_value: expected %0d, got %0d", want.s_value, s_value);
            fail_count++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            fail_count++;
          end
          if (bad_channel !== want.bad_channel) begin
            $error("bad_channel: expected %0b, got %0b", want.bad_channel, bad_channel);
            fail_count++;
          end
          if (final_out !== want.final_out) begin
            $error("final_out: expected %0b, got %0b", want.final_out, final_out);
            fail_count++;
          end
        end
      end
      if (config_write) begin
        chan_limit = config_data;
      end
    end
  end

  task automatic write_config(input logic [glrs_pkg::CFG_W-1:0] value);
    item_valid <= 1'b0;
    while (state_results.size() != 0) @(negedge clk);
    config_write <= 1'b1;
    config_data <= value;
    @(negedge clk);
    config_write <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [glrs_pkg::CH_W-1:0] ch,
                           input logic [glrs_pkg::GATE_W-1:0] g,
                           input logic signed [glrs_pkg::VAL_W-1:0] x,
                           input logic fin, input bit typed, input scan_result_t res);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else if ($urandom_range(0, 39) == 0) begin
      tx_calm = $urandom_range(10, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= op;
    channel <= ch;
    gate <= g;
    x_value <= x;
    final_step <= fin;
    note_typed = typed;
    note_exp = res;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && item_ready));
    @(negedge clk);
  endtask

  initial begin : result_sink
    int stall;
    result_ready = 1'b0;
    rx_calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_calm > 0) begin
        stall = 0;
        rx_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        rx_calm = $urandom_range(10, 60);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    scan_row_t                         r;
    scan_result_t                      res;
    logic [glrs_pkg::CFG_W-1:0]        use_cfg;
    logic [glrs_pkg::CH_W-1:0]         ch;
    logic [glrs_pkg::GATE_W-1:0]       g;
    logic signed [glrs_pkg::VAL_W-1:0] x;
    logic                              op;
    logic                              fin;
    int                                phase_items;
    int                                sent;
    int                                top_ch;
    int                                seq_len;
    rst = 1'b1;
    config_write = 1'b0;
    config_data = '0;
    item_valid = 1'b0;
    opcode = glrs_pkg::OP_STEP;
    channel = '0;
    gate = '0;
    x_value = '0;
    final_step = 1'b0;
    note_typed = 1'b0;
    note_exp = '0;
    fail_count = 0;
    tx_calm = 0;

    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 0, glrs_pkg::GATE_ONE, 0, 0,
                                1, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 0, 0, glrs_pkg::VAL_MAX, 0,
                                1, glrs_pkg::VAL_MAX, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 0, glrs_pkg::GATE_ONE, 1, 1,
                                1, glrs_pkg::VAL_MAX, 1, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 63, 17'h1FFFF, glrs_pkg::VAL_MIN,
                                1, 1, glrs_pkg::VAL_MIN, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 63, glrs_pkg::GATE_ONE, -1, 0,
                                1, glrs_pkg::VAL_MIN, 1, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 63, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 1, 17'h1FFFF, 65536, 0,
                                1, 65536, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 1, 17'h1FFFF, 0, 0,
                                1, 65536, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 1, 32768, 0, 1, 1, 32768, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 2, 0, 1, 0, 1, 1, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 2, 32768, 0, 0, 1, 1, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 3, 0, -1, 0, 1, -1, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 3, 32768, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 42, 65535, glrs_pkg::VAL_MIN, 1,
                                1, glrs_pkg::VAL_MIN, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 42, 65535, glrs_pkg::VAL_MIN, 0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 21, 17'h0AAAA, 32'h5A5AA5A5, 0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 21, 17'h15555, 32'h12345678, 1,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_CFG, glrs_pkg::OP_STEP, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 1, glrs_pkg::GATE_ONE, 5, 1,
                                1, 0, 0, 1));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_LOAD, 63, 0, 7, 0, 1, 0, 0, 1));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 0, glrs_pkg::GATE_ONE,
                                glrs_pkg::VAL_MIN, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_CFG, glrs_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 0, 0, 0, 1, 1, 0, 0, 1));
    dir_rows.push_back(make_row(ROW_CFG, glrs_pkg::OP_STEP, 0, 0, 127, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_ITEM, glrs_pkg::OP_STEP, 63, glrs_pkg::GATE_ONE, 0, 0,
                                0, 0, 0, 0));
    dir_rows.push_back(make_row(ROW_CFG, glrs_pkg::OP_STEP, 0, 0, 64, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        write_config(r.x[glrs_pkg::CFG_W-1:0]);
      end else begin
        res.s_value = r.s;
        res.saturated = r.sat;
        res.bad_channel = r.bad;
        res.final_out = r.fin;
        send_item(r.op, r.ch, r.g, r.x, r.fin, r.typed, res);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 7: use_cfg = glrs_pkg::CHANNELS_RESET;
        1: use_cfg = glrs_pkg::CFG_W'(1);
        2: use_cfg = glrs_pkg::CFG_W'(0);
        3: use_cfg = glrs_pkg::CFG_W'(127);
        default: use_cfg = glrs_pkg::CFG_W'($urandom_range(2, 63));
      endcase
      write_config(use_cfg);
      phase_items = (use_cfg == 0) ? 60 : 260;
      top_ch = (use_cfg == 0 || use_cfg > glrs_pkg::CHANNELS) ? glrs_pkg::CHANNELS - 1
                                                               : use_cfg - 1;
      sent = 0;
      while (sent < phase_items) begin
        ch = ($urandom_range(0, 6) == 0) ? glrs_pkg::CH_W'($urandom_range(0, 63))
                                         : glrs_pkg::CH_W'($urandom_range(0, top_ch));
        seq_len = $urandom_range(1, 12);
        for (int k = 0; k < seq_len; k++) begin
          op = (k == 0 && $urandom_range(0, 9) < 7) ? glrs_pkg::OP_LOAD : glrs_pkg::OP_STEP;
          fin = (k == seq_len - 1);
          case ($urandom_range(0, 19))
            0, 1: g = '0;
            2, 3: g = glrs_pkg::GATE_ONE;
            4: g = glrs_pkg::GATE_W'($urandom_range(glrs_pkg::GATE_ONE + 1, 17'h1FFFF));
            5: g = glrs_pkg::GATE_W'($urandom_range(glrs_pkg::GATE_ONE - 8,
                                                    glrs_pkg::GATE_ONE - 1));
            default: g = glrs_pkg::GATE_W'($urandom_range(0, glrs_pkg::GATE_ONE));
          endcase
          case ($urandom_range(0, 9))
            0: x = glrs_pkg::VAL_MAX;
            1: x = glrs_pkg::VAL_MIN;
            2, 3, 4: x = int'($urandom_range(0, 2097151)) - 1048576;
            default: x = $urandom;
          endcase
          if ($urandom_range(0, 19) == 0) begin
            op = 1'($urandom_range(0, 1));
            fin = 1'($urandom_range(0, 1));
            ch = glrs_pkg::CH_W'($urandom_range(0, 63));
          end
          send_item(op, ch, g, x, fin, 1'b0, '0);
          sent++;
        end
      end
    end

    item_valid <= 1'b0;
    while (state_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
